// ===== sv/framed_packet_receiver_with_sum_check_core_macros.svh =====
// assertion macros shared by the receiver checker
`ifndef FRAMED_PACKET_RECEIVER_WITH_SUM_CHECK_CORE_MACROS_SVH
`define FRAMED_PACKET_RECEIVER_WITH_SUM_CHECK_CORE_MACROS_SVH

// same-cycle implication, held off while reset is active
`define FPR_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("receiver check failed");

// next-cycle implication, held off while reset is active
`define FPR_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("receiver check failed");

`endif

// ===== sv/fpr_pkg.sv =====
// shared constants, types and the sum check for the framed packet receiver
`timescale 1ns / 1ps
`default_nettype none

package fpr_pkg;

    localparam int FRAME_BYTES = 8;
    // cells hold frame bytes 0 to FRAME_BYTES-2, the tail byte is the live input
    localparam int NUM_CELLS   = FRAME_BYTES - 1;
    localparam int POS_W       = $clog2(FRAME_BYTES + 1);

    // cell that holds frame byte k when the tail beat arrives
    localparam int CELL_CMD    = FRAME_BYTES - 2 - 1;
    localparam int CELL_PA     = FRAME_BYTES - 2 - 2;
    localparam int CELL_PB     = FRAME_BYTES - 2 - 3;
    localparam int CELL_PC     = FRAME_BYTES - 2 - 4;
    localparam int CELL_SUM_LO = FRAME_BYTES - 2 - 5;
    localparam int CELL_SUM_HI = FRAME_BYTES - 2 - 6;

    // register map
    localparam int ADDR_W = 3;
    localparam logic [0:0] REG_HEADER = 1'b0;
    localparam logic [0:0] REG_TAIL   = 1'b1;

    localparam logic [7:0] HEADER_RESET = 8'd170;
    localparam logic [7:0] TAIL_RESET   = 8'd85;

    typedef struct packed {
        logic shift;
        logic emit;
    } ctrl_t;

    typedef struct packed {
        logic       sum_ok;
        logic [7:0] payload_c;
        logic [7:0] payload_b;
        logic [7:0] payload_a;
        logic [7:0] command;
    } result_t;

    // bytes 5 and 6 against the 16-bit sum of bytes 1 to 3
    function automatic logic sum_check(input logic [7:0] b1, input logic [7:0] b2,
                                       input logic [7:0] b3, input logic [7:0] lo,
                                       input logic [7:0] hi);
        logic [9:0] sum;
        sum = {2'b00, b1} + {2'b00, b2} + {2'b00, b3};
        return (lo == sum[7:0]) && (hi == {6'b000000, sum[9:8]});
    endfunction

endpackage

`default_nettype wire

// ===== sv/fpr_cell.sv =====
// one byte cell of the frame shift chain
`timescale 1ns / 1ps
`default_nettype none

module fpr_cell
    import fpr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       shift,
    input  wire logic [7:0] d_in,
    output logic [7:0]      q
);

    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    // take the neighbour's byte on every accepted beat
    always_comb
    begin
        byte_next = shift ? d_in : byte_reg;
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

    assign q = byte_reg;

endmodule

`default_nettype wire

// ===== sv/fpr_ctrl.sv =====
// frame position tracking, tail check and input flow control
`timescale 1ns / 1ps
`default_nettype none

module fpr_ctrl
    import fpr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    input  wire logic [7:0] rx_byte,
    input  wire logic [7:0] header_byte,
    input  wire logic [7:0] tail_byte,
    input  wire logic       out_valid,
    input  wire logic       m_tready,
    output logic            s_tready,
    output ctrl_t           ctrl
);

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic             idle;
    logic             last_pending;
    logic             beat;

    // position above the frame length counts as idle
    assign idle         = (pos_reg == '0) || (pos_reg > POS_W'(FRAME_BYTES));
    assign last_pending = (pos_reg == POS_W'(FRAME_BYTES));

    // only the last frame byte needs room in the output register
    assign s_tready = !last_pending || !out_valid || m_tready;
    assign beat     = s_tvalid && s_tready;

    // next position
    always_comb
    begin
        pos_next = pos_reg;
        if (idle)
        begin
            pos_next = '0;
            if (beat && (rx_byte == header_byte))
            begin
                pos_next = POS_W'(2);
            end
        end
        else if (beat)
        begin
            pos_next = last_pending ? '0 : pos_reg + POS_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

    // chain moves on every beat, result only on a matching tail
    assign ctrl.shift = beat;
    assign ctrl.emit  = beat && last_pending && (rx_byte == tail_byte);

endmodule

`default_nettype wire

// ===== sv/fpr_out.sv =====
// result output register on the master side
`timescale 1ns / 1ps
`default_nettype none

module fpr_out
    import fpr_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    emit,
    input  wire result_t result,
    input  wire logic    m_tready,
    output logic         m_tvalid,
    output logic [31:0]  m_tdata,
    output logic [0:0]   m_tuser
);

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;
    result_t data_next;

    // load on emit, drop once taken
    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (emit)
        begin
            valid_next = 1'b1;
            data_next  = result;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {data_reg.payload_c, data_reg.payload_b,
                       data_reg.payload_a, data_reg.command};
    assign m_tuser  = data_reg.sum_ok;

endmodule

`default_nettype wire

// ===== sv/framed_packet_receiver_with_sum_check_core.sv =====
// top level of the framed packet receiver with additive sum check
//
//  channel   dir  fields (lsb first)                                  beat when
//  s_axis    in   tdata: rx_byte                                      s_tvalid & s_tready
//  m_axis    out  tdata: command, payload_a, payload_b, payload_c;    m_tvalid & m_tready
//                 tuser: sum_ok
//  apb       in   0x0 header_byte, 0x4 tail_byte                      psel & penable & pwrite
//
//  one received byte per cycle while s_tready is high, through a chain of seven byte cells
//  a result appears in the output register in the cycle after the tail beat
//  rst_n clears the frame position and the output valid and presets the two registers
//  s_tready drops only on the last frame byte while an earlier result waits untaken
`timescale 1ns / 1ps
`default_nettype none

module framed_packet_receiver_with_sum_check_core
    import fpr_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // slave side
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [7:0]        s_tdata,   // [7:0] rx_byte
    // master side
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [31:0]            m_tdata,   // [7:0] command, [15:8] payload_a,
                                              // [23:16] payload_b, [31:24] payload_c
    output logic [0:0]             m_tuser,   // [0] sum_ok
    // configuration
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    logic [7:0] header_reg;
    logic [7:0] header_next;
    logic [7:0] tail_reg;
    logic [7:0] tail_next;
    logic       cfg_wr;
    ctrl_t      ctrl;
    result_t    result;
    logic [7:0] cell_q [NUM_CELLS];

    // register writes
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        header_next = header_reg;
        tail_next   = tail_reg;
        if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_HEADER: header_next = pwdata[7:0];
                REG_TAIL:   tail_next   = pwdata[7:0];
                default:    header_next = header_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg <= HEADER_RESET;
            tail_reg   <= TAIL_RESET;
        end
        else
        begin
            header_reg <= header_next;
            tail_reg   <= tail_next;
        end
    end

    // register reads
    always_comb
    begin
        unique case (paddr[2])
            REG_HEADER: prdata = {24'h000000, header_reg};
            REG_TAIL:   prdata = {24'h000000, tail_reg};
            default:    prdata = '0;
        endcase
    end

    // frame position and flow control
    fpr_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .rx_byte     (s_tdata),
        .header_byte (header_reg),
        .tail_byte   (tail_reg),
        .out_valid   (m_tvalid),
        .m_tready    (m_tready),
        .s_tready    (s_tready),
        .ctrl        (ctrl)
    );

    // byte chain, cell 0 takes the live byte
    for (genvar i = 0; i < NUM_CELLS; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            fpr_cell u_cell (
                .clk   (clk),
                .shift (ctrl.shift),
                .d_in  (s_tdata),
                .q     (cell_q[i])
            );
        end
        else
        begin : g_body
            fpr_cell u_cell (
                .clk   (clk),
                .shift (ctrl.shift),
                .d_in  (cell_q[i-1]),
                .q     (cell_q[i])
            );
        end
    end

    // result fields and sum check at the tail beat
    always_comb
    begin
        result.command   = cell_q[CELL_CMD];
        result.payload_a = cell_q[CELL_PA];
        result.payload_b = cell_q[CELL_PB];
        result.payload_c = cell_q[CELL_PC];
        result.sum_ok    = sum_check(cell_q[CELL_CMD], cell_q[CELL_PA], cell_q[CELL_PB],
                                     cell_q[CELL_SUM_LO], cell_q[CELL_SUM_HI]);
    end

    fpr_out u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .emit     (ctrl.emit),
        .result   (result),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

// ===== sv/fpr_checker.sv =====
// port-level checker for the framed packet receiver, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "framed_packet_receiver_with_sum_check_core_macros.svh"

module fpr_checker
    import fpr_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              s_tvalid,
    input wire logic              s_tready,
    input wire logic              m_tvalid,
    input wire logic              m_tready,
    input wire logic [31:0]       m_tdata,
    input wire logic [0:0]        m_tuser,
    input wire logic              psel,
    input wire logic              pready
);

    logic [POS_W-1:0] beats_reg;
    logic [POS_W-1:0] beats_next;
    logic             valid_prev_reg;
    logic             beat;
    logic             new_result;

    assign beat       = s_tvalid && s_tready;
    assign new_result = m_tvalid && !valid_prev_reg;

    // input beats seen since the last fresh result, saturating at a frame
    always_comb
    begin
        beats_next = new_result ? '0 : beats_reg;
        if (beat && (beats_next < POS_W'(FRAME_BYTES)))
        begin
            beats_next = beats_next + POS_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beats_reg      <= '0;
            valid_prev_reg <= 1'b0;
        end
        else
        begin
            beats_reg      <= beats_next;
            valid_prev_reg <= m_tvalid;
        end
    end

    // a waiting result stays offered with the same fields
    `FPR_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // a result only follows an accepted input beat
    `FPR_ASSERT_IMP(a_out_after_beat, $rose(m_tvalid), $past(beat))

    // a whole frame of beats lies between fresh results
    `FPR_ASSERT_IMP(a_frame_length, $rose(m_tvalid), beats_reg >= POS_W'(FRAME_BYTES))

    // the register port never waits
    `FPR_ASSERT_IMP(a_apb_ready, psel, pready)

endmodule

bind framed_packet_receiver_with_sum_check_core fpr_checker u_fpr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .pready   (pready)
);

`default_nettype wire

// ===== dv/tb_top.sv =====
// self-checking testbench for the framed packet receiver with additive sum check
`timescale 1ns / 1ps

module tb_top;
    import fpr_pkg::*;

    localparam logic [ADDR_W-1:0] HEADER_ADDR = ADDR_W'(4 * REG_HEADER);
    localparam logic [ADDR_W-1:0] TAIL_ADDR   = ADDR_W'(4 * REG_TAIL);
    localparam int SETTLE_CYCLES = 4;
    localparam int STALL_LIMIT   = 3000;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASE_BYTES   = 255;
    localparam int MAX_PRINTS    = 20;

    typedef enum int {
        CHK_GOOD,
        CHK_BAD_LO,
        CHK_BAD_HI,
        CHK_RANDOM
    } sum_mode_e;

    logic              clk      = 1'b0;
    logic              rst_n    = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata  = 8'd0;   // [7:0] rx_byte
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [31:0]       m_tdata;           // [7:0] command, [15:8] payload_a,
                                          // [23:16] payload_b, [31:24] payload_c
    logic [0:0]        m_tuser;           // [0] sum_ok
    logic              psel     = 1'b0;
    logic              penable  = 1'b0;
    logic              pwrite   = 1'b0;
    logic [ADDR_W-1:0] paddr    = '0;
    logic [31:0]       pwdata   = 32'd0;
    logic [31:0]       prdata;
    logic              pready;

    // predictor state
    logic [7:0] hdr_reg = HEADER_RESET;
    logic [7:0] tail_reg = TAIL_RESET;
    logic [3:0] frame_pos = 4'd0;
    logic [7:0] frame_buf [FRAME_BYTES];
    result_t    expected_frames [$];

    // stimulus and idling control
    logic [7:0] byte_queue [$];
    logic       in_fire        = 1'b0;
    bit         src_gaps_on    = 1'b1;
    bit         sink_gaps_on   = 1'b1;
    int         src_gap_left   = 0;
    int         sink_stall_left = 0;
    int         hold_left      = 0;
    int         hold_requests  = 0;
    int         holds_served   = 0;
    int         idle_cycles    = 0;
    int         mismatch_count = 0;

    framed_packet_receiver_with_sum_check_core u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // clock
    initial
    begin
        forever #1 clk = ~clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatch_count < MAX_PRINTS)
            $display("ERROR at %0t: %s", $time, what);
        mismatch_count++;
    endtask

    // predicts the result, if any, caused by one received byte
    task automatic deframe_byte(input logic [7:0] b);
        logic [15:0] total;
        result_t     r;
        if (frame_pos > FRAME_BYTES)
            frame_pos = 4'd0;
        if (frame_pos == 4'd0)
        begin
            if (b != hdr_reg)
                return;
            frame_pos = 4'd1;
        end
        frame_buf[frame_pos - 4'd1] = b;
        frame_pos = frame_pos + 4'd1;
        if (frame_pos != FRAME_BYTES + 1)
            return;
        frame_pos = 4'd0;
        // tail mismatch drops the frame silently
        if (b != tail_reg)
            return;
        total = 16'(frame_buf[1]) + 16'(frame_buf[2]) + 16'(frame_buf[3]);
        r.command   = frame_buf[1];
        r.payload_a = frame_buf[2];
        r.payload_b = frame_buf[3];
        r.payload_c = frame_buf[4];
        r.sum_ok    = (frame_buf[5] == total[7:0]) && (frame_buf[6] == total[15:8]);
        expected_frames.push_back(r);
    endtask

    // source driver
    always @(negedge clk)
    begin
        if (!s_tvalid || in_fire)
        begin
            if (src_gap_left > 0)
            begin
                src_gap_left--;
                s_tvalid <= 1'b0;
            end
            else if (byte_queue.size() > 0)
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= byte_queue.pop_front();
                if (src_gaps_on)
                    src_gap_left = gap_len();
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // sink back-pressure, with an occasional long hold-off
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (hold_requests != holds_served)
        begin
            holds_served++;
            hold_left = HOLD_CYCLES - 1;
            m_tready <= 1'b0;
        end
        else if (sink_stall_left > 0)
        begin
            sink_stall_left--;
            m_tready <= 1'b0;
        end
        else if (sink_gaps_on && $urandom_range(0, 3) == 0)
        begin
            sink_stall_left = gap_len();
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // monitor: input beats feed the predictor, output beats are checked
    always @(posedge clk)
    begin
        result_t want;
        in_fire <= rst_n && s_tvalid && s_tready;
        if (rst_n && s_tvalid && s_tready)
            deframe_byte(s_tdata);
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_frames.size() == 0)
                report_mismatch($sformatf("result with none expected: tdata %08h tuser %0b",
                                          m_tdata, m_tuser));
            else
            begin
                want = expected_frames.pop_front();
                if (m_tdata[7:0] != want.command)
                    report_mismatch($sformatf("command: expected %02h got %02h",
                                              want.command, m_tdata[7:0]));
                if (m_tdata[15:8] != want.payload_a)
                    report_mismatch($sformatf("payload_a: expected %02h got %02h",
                                              want.payload_a, m_tdata[15:8]));
                if (m_tdata[23:16] != want.payload_b)
                    report_mismatch($sformatf("payload_b: expected %02h got %02h",
                                              want.payload_b, m_tdata[23:16]));
                if (m_tdata[31:24] != want.payload_c)
                    report_mismatch($sformatf("payload_c: expected %02h got %02h",
                                              want.payload_c, m_tdata[31:24]));
                if (m_tuser[0] !== want.sum_ok)
                    report_mismatch($sformatf("sum_ok: expected %0b got %0b",
                                              want.sum_ok, m_tuser[0]));
            end
        end
    end

    // watchdog on cycles without any beat
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // register write with setup and access phases, predictor copy updated on the access edge
    task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [7:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {24'd0, value};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (addr == HEADER_ADDR)
            hdr_reg = value;
        else if (addr == TAIL_ADDR)
            tail_reg = value;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // wait until every byte is sent and every result has come out
    task automatic drain_pipeline();
        while (byte_queue.size() != 0 || s_tvalid || expected_frames.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // one whole frame with a chosen check outcome and tail
    task automatic queue_frame(input logic [7:0] cmd, input logic [7:0] pa,
                               input logic [7:0] pb, input logic [7:0] pc,
                               input sum_mode_e mode, input bit tail_ok);
        logic [15:0] total;
        logic [7:0]  lo;
        logic [7:0]  hi;
        total = 16'(cmd) + 16'(pa) + 16'(pb);
        lo = total[7:0];
        hi = total[15:8];
        case (mode)
            CHK_BAD_LO: lo = lo + 8'($urandom_range(1, 255));
            CHK_BAD_HI: hi = hi + 8'($urandom_range(1, 255));
            CHK_RANDOM:
            begin
                lo = 8'($urandom);
                hi = 8'($urandom);
            end
            default: ;
        endcase
        byte_queue.push_back(hdr_reg);
        byte_queue.push_back(cmd);
        byte_queue.push_back(pa);
        byte_queue.push_back(pb);
        byte_queue.push_back(pc);
        byte_queue.push_back(lo);
        byte_queue.push_back(hi);
        byte_queue.push_back(tail_ok ? tail_reg : tail_reg + 8'($urandom_range(1, 255)));
    endtask

    // mostly good frames, some cut short, some line noise
    task automatic random_traffic(input int n_bytes);
        int        start;
        int        r;
        int        k;
        logic [7:0] v;
        sum_mode_e mode;
        start = byte_queue.size();
        while (byte_queue.size() - start < n_bytes)
        begin
            r = $urandom_range(0, 99);
            if (r < 75)
            begin
                k = $urandom_range(0, 9);
                if (k < 6)
                    mode = CHK_GOOD;
                else if (k < 7)
                    mode = CHK_BAD_LO;
                else if (k < 8)
                    mode = CHK_BAD_HI;
                else
                    mode = CHK_RANDOM;
                queue_frame(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                            mode, $urandom_range(0, 9) != 0);
            end
            else if (r < 85)
            begin
                byte_queue.push_back(hdr_reg);
                repeat ($urandom_range(1, 6))
                    byte_queue.push_back(8'($urandom));
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                begin
                    v = 8'($urandom);
                    if (v == hdr_reg && $urandom_range(0, 7) != 0)
                        v = ~v;
                    byte_queue.push_back(v);
                end
            end
        end
    endtask

    // stimulus sequence
    initial
    begin
        logic [7:0] hdr_plan  [5];
        logic [7:0] tail_plan [5];
        hdr_plan  = '{8'h00, 8'hFF, 8'h5A, 8'h00, HEADER_RESET};
        tail_plan = '{8'hFF, 8'h00, 8'h5A, 8'h00, TAIL_RESET};

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: noise, largest sum, header as data, dropped frame ending
        // in the header value, then high byte of the sum wrong
        byte_queue.push_back(8'h00);
        byte_queue.push_back(8'hFF);
        queue_frame(8'hFF, 8'hFF, 8'hFF, 8'h00, CHK_GOOD, 1'b1);
        byte_queue.push_back(hdr_reg);
        byte_queue.push_back(8'h00);
        byte_queue.push_back(hdr_reg);
        byte_queue.push_back(8'h00);
        byte_queue.push_back(8'hFF);
        byte_queue.push_back(hdr_reg);
        byte_queue.push_back(8'h00);
        byte_queue.push_back(hdr_reg);
        queue_frame(8'h01, 8'h02, 8'h03, 8'h80, CHK_BAD_HI, 1'b1);
        drain_pipeline();

        // random phases, each under its own header and tail setting
        for (int p = 0; p < 5; p++)
        begin
            if (p == 3)
            begin
                hdr_plan[p]  = 8'($urandom);
                tail_plan[p] = 8'($urandom);
            end
            write_reg(HEADER_ADDR, hdr_plan[p]);
            write_reg(TAIL_ADDR, tail_plan[p]);
            src_gaps_on  = (p != 1 && p != 2);
            sink_gaps_on = (p != 1);
            random_traffic(PHASE_BYTES);
            // long sink hold-off while the source keeps streaming
            if (p == 2)
                hold_requests++;
            drain_pipeline();
        end

        if (mismatch_count == 0 && expected_frames.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
